// ----- hw/rtl/servo_throttle_teach_controller_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SERVO_THROTTLE_TEACH_CONTROLLER_CORE_MACROS_SVH
`define SERVO_THROTTLE_TEACH_CONTROLLER_CORE_MACROS_SVH
`define STC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/stc_pkg.sv -----
package stc_pkg;
  localparam int unsigned AdcW = 10;
  localparam int unsigned AngW = 8;
  localparam int unsigned TmrW = 16;

  localparam logic [2:0] ModeMain     = 3'd0;
  localparam logic [2:0] ModeStore    = 3'd1;
  localparam logic [2:0] ModeThrottle = 3'd2;
  localparam logic [2:0] ModeLimit    = 3'd3;
  localparam logic [2:0] ModeReverse  = 3'd4;
  localparam logic [2:0] ModeShort    = 3'd5;
  localparam logic [2:0] ModeCalib    = 3'd6;
  localparam logic [2:0] BtnStore     = 3'd1;

  localparam logic [2:0] PcNone     = 3'd0;
  localparam logic [2:0] PcThrottle = 3'd1;
  localparam logic [2:0] PcLimit    = 3'd2;
  localparam logic [2:0] PcReverse  = 3'd3;
  localparam logic [2:0] PcShort    = 3'd4;
  localparam logic [2:0] PcCalib    = 3'd5;

  localparam logic [TmrW-1:0] TeachMinMs = 16'd1300;
  localparam logic [TmrW-1:0] TeachMaxMs = 16'd1600;
  localparam logic [TmrW-1:0] MoveIntervalRst = 16'd15;

  typedef struct packed {
    logic [9:0] adc_sample;
    logic [2:0] button_code;
    logic [7:0] elapsed_ms;
  } stc_in_t;

  typedef struct packed {
    logic [7:0] servo_position;
    logic       position_written;
    logic [2:0] control_mode;
    logic [1:0] flash_count;
    logic [2:0] persist_code;
    logic [9:0] persist_value;
    logic [9:0] persist_second;
  } stc_out_t;
endpackage

// ----- hw/rtl/servo_throttle_teach_controller_core.sv -----
// Servo throttle teach controller. One input word is one control tick; one
// result word comes back per tick. The range mapping divides a signed product
// by the calibrated span with a restoring divider that retires one quotient
// bit per cycle. After the input word is taken, the divide state produces the
// quotient bits and a finish state updates the state and loads the result
// register. The input stalls while a tick is in work and while the result word
// waits, so a new input word is not taken until the result has been taken.
// move_interval_ms is written on its own valid/ready port, which is ready only
// while no tick is in work and no result word waits.
module servo_throttle_teach_controller_core
  import stc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  stc_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output stc_out_t  out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned NumW = 19; // |(adc-low)*180| < 2^18, one sign margin
  localparam int unsigned CntW = 5;

  typedef enum logic [1:0] {StIdle, StDiv, StFin} state_e;

  state_e      state_q;
  logic [CntW-1:0] cnt_q;
  stc_in_t     in_q;
  logic [NumW-1:0] rem_q, quo_q;
  logic [NumW-1:0] num_abs_q;
  logic [10:0] den_abs_q;
  logic        neg_q, zero_q;
  logic        out_valid_q;
  stc_out_t    out_q;

  logic [15:0] interval_q;
  logic [2:0]  mode_q;
  logic [1:0]  cstep_q;
  logic        rev_q, sgl_q;
  logic [7:0]  lim_q, thr_q, pos_q;
  logic [9:0]  cal_lo_q, cal_hi_q;
  logic [TmrW-1:0] mtmr_q, ttmr_q;

  // setup of the division
  logic signed [10:0] diff_s, span_s;
  logic signed [19:0] prod_s;
  always_comb begin
    diff_s = $signed({1'b0, in_data_i.adc_sample}) - $signed({1'b0, cal_lo_q});
    span_s = $signed({1'b0, cal_hi_q}) - $signed({1'b0, cal_lo_q});
    prod_s = diff_s * 20'sd180;
  end

  // one restoring step
  logic [NumW:0] trial;
  logic [NumW-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[NumW-2:0], num_abs_q[NumW-1]};
    trial  = {1'b0, rem_sh} - {{(NumW-10){1'b0}}, den_abs_q};
  end

  // tick evaluation in the finish cycle
  logic signed [NumW:0] q_s, v_s;
  logic [7:0]  val0, val;
  logic [16:0] msum, tsum;
  logic [TmrW-1:0] mt, tt;
  logic [2:0]  mode_d;
  logic [1:0]  cstep_d, flash;
  logic        rev_d, sgl_d, wr;
  logic [7:0]  lim_d, thr_d, pos_d;
  logic [9:0]  lo_d, hi_d, pval, psec;
  logic [2:0]  pcode;
  always_comb begin
    q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    // reversed mapping negates the quotient and starts from full scale
    v_s = rev_q ? 20'sd180 - q_s : q_s;
    if (zero_q || v_s < 0) val0 = 8'd0;
    else if (v_s > 20'sd180) val0 = 8'd180;
    else val0 = v_s[7:0];
    msum = {1'b0, mtmr_q} + {9'd0, in_q.elapsed_ms};
    tsum = {1'b0, ttmr_q} + {9'd0, in_q.elapsed_ms};
    mt = msum[16] ? 16'hFFFF : msum[15:0];
    tt = tsum[16] ? 16'hFFFF : tsum[15:0];
    val = val0; mode_d = mode_q; cstep_d = cstep_q; rev_d = rev_q; sgl_d = sgl_q;
    lim_d = lim_q; thr_d = thr_q; lo_d = cal_lo_q; hi_d = cal_hi_q;
    flash = 2'd0; pcode = PcNone; pval = 10'd0; psec = 10'd0;
    case (mode_q)
      ModeMain: begin
        if (in_q.button_code > BtnStore && in_q.button_code <= ModeCalib)
          mode_d = in_q.button_code;
        if (!rev_q) begin
          if (val0 > 8'd178 && sgl_q) val = lim_q;
          else if (val0 < lim_q) val = lim_q;
          else if (val0 < thr_q) val = thr_q;
        end else begin
          if (val0 < 8'd2 && sgl_q) val = lim_q;
          else if (val0 > lim_q) val = lim_q;
          else if (val0 > thr_q) val = thr_q;
        end
      end
      ModeStore: mode_d = ModeMain;
      ModeThrottle: begin
        thr_d = val0;
        if (in_q.button_code == BtnStore) begin
          pcode = PcThrottle; pval = {2'd0, val0}; mode_d = ModeStore;
        end
      end
      ModeLimit: begin
        lim_d = val0;
        if (in_q.button_code == BtnStore) begin
          pcode = PcLimit; pval = {2'd0, val0}; mode_d = ModeStore;
        end
      end
      ModeReverse: begin
        rev_d = ~rev_q; pcode = PcReverse; pval = {9'd0, ~rev_q}; mode_d = ModeStore;
      end
      ModeShort: begin
        if (in_q.button_code == BtnStore) begin
          mode_d = ModeStore; pcode = PcShort; pval = {9'd0, sgl_q};
        end else if (tt >= TeachMinMs) begin
          tt = '0; sgl_d = ~sgl_q; flash = sgl_q ? 2'd2 : 2'd1;
        end
      end
      ModeCalib: begin
        case (cstep_q)
          2'd0: begin
            if (in_q.button_code == BtnStore) cstep_d = 2'd1;
            else begin
              lo_d = in_q.adc_sample;
              if (tt >= TeachMinMs) begin tt = '0; flash = 2'd1; end
            end
          end
          2'd1: begin
            if (in_q.button_code == BtnStore) cstep_d = 2'd2;
            else begin
              hi_d = in_q.adc_sample;
              if (tt >= TeachMaxMs) begin tt = '0; flash = 2'd2; end
            end
          end
          2'd2: begin
            if (cal_lo_q > cal_hi_q) begin lo_d = cal_hi_q; hi_d = cal_lo_q; end
            cstep_d = 2'd3;
          end
          default: begin
            cstep_d = 2'd0; mode_d = ModeStore; pcode = PcCalib;
            pval = cal_lo_q; psec = cal_hi_q;
          end
        endcase
      end
      default: ;
    endcase
    pos_d = pos_q; wr = 1'b0;
    if (mt >= interval_q) begin
      if (pos_q < val) pos_d = pos_q + 8'd1;
      else if (pos_q > val) pos_d = pos_q - 8'd1;
      mt = '0; wr = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; out_valid_q <= 1'b0;
      interval_q <= MoveIntervalRst; mode_q <= ModeMain; cstep_q <= 2'd0;
      rev_q <= 1'b0; sgl_q <= 1'b1; lim_q <= 8'd10; thr_q <= 8'd20;
      cal_lo_q <= 10'd538; cal_hi_q <= 10'd1023; pos_q <= 8'd90;
      mtmr_q <= '0; ttmr_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) interval_q <= cfg_data_i;
      case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            in_q      <= in_data_i;
            neg_q     <= (prod_s < 0) ^ (span_s < 0);
            zero_q    <= (span_s == 0);
            num_abs_q <= prod_s < 0 ? NumW'(-prod_s) : NumW'(prod_s);
            den_abs_q <= span_s < 0 ? 11'(-span_s) : 11'(span_s);
            rem_q     <= '0;
            cnt_q     <= '0;
            state_q   <= StDiv;
          end
        end
        StDiv: begin
          // shift in one numerator bit, retire one quotient bit
          num_abs_q <= {num_abs_q[NumW-2:0], 1'b0};
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0]; quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumW - 1)) state_q <= StFin;
        end
        StFin: begin
          mode_q <= mode_d; cstep_q <= cstep_d; rev_q <= rev_d; sgl_q <= sgl_d;
          lim_q <= lim_d; thr_q <= thr_d; cal_lo_q <= lo_d; cal_hi_q <= hi_d;
          pos_q <= pos_d; mtmr_q <= mt; ttmr_q <= tt;
          out_q <= '{servo_position: pos_d, position_written: wr,
                     control_mode: mode_d, flash_count: flash,
                     persist_code: pcode, persist_value: pval,
                     persist_second: psec};
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/stc_checker.sv -----
`include "servo_throttle_teach_controller_core_macros.svh"
module stc_checker
  import stc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input stc_out_t out_data_o,
  input logic     cfg_ready_o
);
  `STC_ASSERT_IMPL(pos_range, clk_i, rst_ni, out_valid_o, out_data_o.servo_position <= 8'd180)
  `STC_ASSERT_IMPL(busy_no_cfg, clk_i, rst_ni, in_stall_o, !cfg_ready_o)
  `STC_ASSERT_NEXT(accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `STC_ASSERT_NEXT(out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
endmodule

bind servo_throttle_teach_controller_core stc_checker u_stc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
  .cfg_ready_o(cfg_ready_o)
);
